// ===== rtl/core/bitset_key_hash_map_top_assert.svh =====
// Assertion macros shared by the hash map RTL.
// Included by the controller and the top level; depends on nothing else.
`ifndef BITSET_KEY_HASH_MAP_TOP_ASSERT_SVH
`define BITSET_KEY_HASH_MAP_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BKH_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BKH_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/bkh_pkg.sv =====
// Package for the bitset key hash map: controller states, command and status structs.
// No dependencies.
`default_nettype none
package bkh_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEARING,
    ST_IDLE,
    ST_MOD_LOW,
    ST_ADD_HIGH,
    ST_MOD_SUM,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic mod_start;  // start a reduction of the working word
    logic add_high;   // working word = hash + key_high
    logic set_addr;   // probe address = reduced hash
    logic rd;         // issue a table read
    logic adv;        // step to the next probe slot
    logic wr_key;     // write key and value at probe address
    logic wr_val;     // write value only
    logic clr_start;  // reset clearing address
    logic clr_wr;     // clear one slot and advance
    logic res_load;   // capture the result
    logic res_found;
    logic res_value;  // take stored value
    logic res_full;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       mod_busy;
    logic       slot_empty;
    logic       slot_match;
    logic       probes_done;
    logic       clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/bkh_datapath.sv =====
// Datapath of the hash map: key registers, serial reducer, probe counters, slot memories.
// Depends on bkh_pkg.
`default_nettype none
module bkh_datapath #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [12:0]           slot_count,
  input  wire logic [1:0]            in_op,
  input  wire logic [63:0]           in_key_low,
  input  wire logic [63:0]           in_key_high,
  input  wire logic [19:0]           in_value,
  input  wire bkh_pkg::cmd_t         cmd,
  output bkh_pkg::sts_t              sts,
  output logic                       res_found,
  output logic [19:0]                res_value,
  output logic                       res_status
);
  import bkh_pkg::*;

  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;

  logic [1:0]    op;
  logic [63:0]   klo, khi;
  logic [19:0]   val;
  logic [CW-1:0] s_eff;
  logic [63:0]   work;
  logic [CW:0]   rem;
  logic [6:0]    bitcnt;
  logic          mod_busy;
  logic [AW-1:0] addr;
  logic [CW-1:0] probes;
  logic [AW-1:0] clr_addr;
  logic [127:0]  rd_key;
  logic [19:0]   rd_val;
  logic [127:0]  key_mem [TABLE_DEPTH];
  logic [19:0]   val_mem [TABLE_DEPTH];
  logic [CW:0]   rem_shift;
  logic [CW:0]   rem_sub;
  logic [CW-1:0] addr_inc;

  // Effective slot count: zero taken as one, saturated at the depth.
  always_comb begin
    if (slot_count == 13'd0) begin
      s_eff = CW'(1);
    end else if ({19'd0, slot_count} > 32'(TABLE_DEPTH)) begin
      s_eff = CW'(TABLE_DEPTH);
    end else begin
      s_eff = CW'(slot_count);
    end
  end

  // One bit of restoring reduction per cycle.
  always_comb begin
    rem_shift = {rem[CW-1:0], work[63]};
    rem_sub   = rem_shift - {1'b0, s_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
      bitcnt   <= 7'd0;
    end else if (cmd.mod_start) begin
      mod_busy <= 1'b1;
      bitcnt   <= 7'd0;
    end else if (mod_busy) begin
      bitcnt <= bitcnt + 7'd1;
      if (bitcnt == 7'd63) begin
        mod_busy <= 1'b0;
      end
    end
  end

  // Working word, remainder and captured transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_op;
      klo  <= in_key_low;
      khi  <= in_key_high;
      val  <= in_value;
      work <= in_key_low;
    end else if (cmd.add_high) begin
      work <= {{(64-CW-1){1'b0}}, rem} + khi;
    end else if (mod_busy) begin
      work <= {work[62:0], 1'b0};
    end
    if (cmd.mod_start) begin
      rem <= '0;
    end else if (mod_busy) begin
      rem <= rem_sub[CW] ? rem_shift : rem_sub;
    end
  end

  // Probe address and probe count.
  assign addr_inc = {1'b0, addr} + CW'(1);
  always_ff @(posedge clk) begin
    if (cmd.set_addr) begin
      addr   <= rem[AW-1:0];
      probes <= '0;
    end else if (cmd.adv) begin
      addr   <= (addr_inc >= s_eff) ? '0 : addr_inc[AW-1:0];
      probes <= probes + CW'(1);
    end
  end

  // Clearing address sweep, starting from slot 0 after reset.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Key memory: one write port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      key_mem[clr_addr] <= '0;
    end else if (cmd.wr_key) begin
      key_mem[addr] <= {khi, klo};
    end
    if (cmd.rd) begin
      rd_key <= key_mem[addr];
    end
  end

  // Value memory: no reset, registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_key || cmd.wr_val) begin
      val_mem[addr] <= val;
    end
    if (cmd.rd) begin
      rd_val <= val_mem[addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_found  <= cmd.res_found;
      res_value  <= cmd.res_value ? rd_val : 20'd0;
      res_status <= cmd.res_full;
    end
  end

  always_comb begin
    sts.op          = op;
    sts.mod_busy    = mod_busy;
    sts.slot_empty  = (rd_key == 128'd0);
    sts.slot_match  = (rd_key == {khi, klo});
    sts.probes_done = (probes + CW'(1) >= s_eff);
    sts.clr_last    = (clr_addr == AW'(TABLE_DEPTH - 1));
  end

endmodule
`default_nettype wire

// ===== rtl/core/bkh_ctrl.sv =====
// Controller state machine of the hash map: sequences hashing, probing, clearing.
// Depends on bkh_pkg and the assertion macro header.
`default_nettype none
`include "bitset_key_hash_map_top_assert.svh"
module bkh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          out_fire,
  output logic               in_ready,
  output logic               out_valid,
  output bkh_pkg::cmd_t      cmd,
  input  wire bkh_pkg::sts_t sts
);
  import bkh_pkg::*;

  state_t state, state_next;
  logic   valid, valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEARING;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

  assign out_valid = valid;

  // Next state and commands.
  always_comb begin
    state_next = state;
    valid_next = valid && !out_fire;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEARING: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !valid;
        if (in_fire) begin
          cmd.load      = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.clr_start = 1'b1;
          state_next    = ST_MOD_LOW;
        end
      end
      ST_MOD_LOW: begin
        if (sts.op == OP_CLEAR) begin
          cmd.clr_wr = 1'b1;
          if (sts.clr_last) begin
            state_next = ST_RESULT;
          end
        end else if (sts.op != OP_LOOKUP && sts.op != OP_INSERT) begin
          state_next = ST_RESULT;
        end else if (!sts.mod_busy) begin
          state_next = ST_ADD_HIGH;
        end
      end
      ST_ADD_HIGH: begin
        // Fold in the high key word and start the second reduction.
        cmd.add_high  = 1'b1;
        cmd.mod_start = 1'b1;
        state_next    = ST_MOD_SUM;
      end
      ST_MOD_SUM: begin
        // Once the second reduction has finished, it gives the home slot.
        if (!sts.mod_busy) begin
          cmd.set_addr = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.slot_empty) begin
          cmd.wr_key     = (sts.op == OP_INSERT);
          cmd.res_load   = 1'b1;
          state_next     = ST_WRITE;
        end else if (sts.slot_match) begin
          cmd.wr_val     = (sts.op == OP_INSERT);
          cmd.res_load   = 1'b1;
          cmd.res_found  = 1'b1;
          cmd.res_value  = (sts.op == OP_LOOKUP);
          state_next     = ST_WRITE;
        end else if (sts.probes_done) begin
          cmd.res_load   = 1'b1;
          cmd.res_full   = 1'b1;
          state_next     = ST_WRITE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_WRITE: begin
        valid_next = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RESULT: begin
        cmd.res_load = 1'b1;
        valid_next   = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BKH_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !in_ready)
  `BKH_ASSERT_IMP(a_no_accept_pending, clk, rst, valid, !in_ready)
  `BKH_ASSERT_NEXT(a_result_follows, clk, rst, state == ST_WRITE, valid)

endmodule
`default_nettype wire

// ===== rtl/core/bitset_key_hash_map_top.sv =====
// Top level of the bitset key hash map: stream ports, slot count register, controller, datapath.
// Depends on bkh_pkg, bkh_ctrl, bkh_datapath and the assertion macro header.
// One transaction at a time. After reset every slot of the table is cleared before the
// first input is taken. A lookup or insert runs two 64-step serial reductions for the home slot,
// then a memory read and then a compare per probed slot, then the ST_WRITE state before the result
// is presented; a clear wipes all TABLE_DEPTH slots, one slot per cycle, and an unused operation
// code goes straight to the result state. The next input is taken once the result has gone.
`default_nettype none
`include "bitset_key_hash_map_top_assert.svh"
module bitset_key_hash_map_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [12:0]  cfg_wr_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: key_low [63:0], key_high [127:64], value [147:128], zero fill to 152
  input  wire logic [151:0] s_axis_tdata,
  // tuser: operation [1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: found [0], stored_value [20:1], status [21], zero fill to 24
  output logic [23:0]       m_axis_tdata
);
  import bkh_pkg::*;

  logic [12:0] slot_count;
  cmd_t        cmd;
  sts_t        sts;
  logic        res_found, res_status;
  logic [19:0] res_value;
  logic        in_fire, out_fire;

  // Slot count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= 13'd4095;
    end else if (cfg_wr_en) begin
      slot_count <= cfg_wr_data;
    end
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {2'b00, res_status, res_value, res_found};

  bkh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

  bkh_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .slot_count  (slot_count),
    .in_op       (s_axis_tuser),
    .in_key_low  (s_axis_tdata[63:0]),
    .in_key_high (s_axis_tdata[127:64]),
    .in_value    (s_axis_tdata[147:128]),
    .cmd         (cmd),
    .sts         (sts),
    .res_found   (res_found),
    .res_value   (res_value),
    .res_status  (res_status)
  );

  `BKH_ASSERT_NEXT(a_out_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BKH_ASSERT_IMP(a_no_in_while_out, clk, rst, m_axis_tvalid, !s_axis_tready)
  `BKH_ASSERT_IMP(a_full_not_found, clk, rst, m_axis_tvalid && m_axis_tdata[21],
                  !m_axis_tdata[0])

endmodule
`default_nettype wire
